// ----- hw/rtl/mchm_pkg.sv -----
// Package with the types, constants and channel codes of the hysteresis monitor.
`timescale 1ns / 1ps

package mchm_pkg;

  localparam int unsigned MV_W   = 16;
  localparam int unsigned TEMP_W = 8;
  localparam int unsigned NCH    = 5;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ID_W   = 8;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [MV_W-1:0]          mv_t;
  typedef logic [NCH-1:0]           mask_t;
  typedef logic [ID_W-1:0]          sensor_id_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ASSERT = 2'd1,
    EV_CLEAR  = 2'd2
  } event_kind_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_TEMP_ASSERT    = 3'd0,
    CFG_TEMP_CLEAR     = 3'd1,
    CFG_V12_LOW_ASSERT = 3'd2,
    CFG_V12_HIGH_ASSERT = 3'd3,
    CFG_V12_LOW_CLEAR  = 3'd4,
    CFG_V12_HIGH_CLEAR = 3'd5,
    CFG_IOUT_ASSERT    = 3'd6,
    CFG_IOUT_CLEAR     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    temp_t temp_assert;
    temp_t temp_clear;
    mv_t   v12_low_assert;
    mv_t   v12_high_assert;
    mv_t   v12_low_clear;
    mv_t   v12_high_clear;
    mv_t   iout_assert;
    mv_t   iout_clear;
  } thr_t;

  localparam temp_t RST_TEMP_ASSERT     = 8'sd85;
  localparam temp_t RST_TEMP_CLEAR      = 8'sd80;
  localparam mv_t   RST_V12_LOW_ASSERT  = 16'd10800;
  localparam mv_t   RST_V12_HIGH_ASSERT = 16'd13200;
  localparam mv_t   RST_V12_LOW_CLEAR   = 16'd11000;
  localparam mv_t   RST_V12_HIGH_CLEAR  = 16'd13000;
  localparam mv_t   RST_IOUT_ASSERT     = 16'd40000;
  localparam mv_t   RST_IOUT_CLEAR      = 16'd38000;

  localparam mv_t V075_LOW_ASSERT_MV  = 16'd675;
  localparam mv_t V075_HIGH_ASSERT_MV = 16'd825;
  localparam mv_t V075_LOW_CLEAR_MV   = 16'd700;
  localparam mv_t V075_HIGH_CLEAR_MV  = 16'd800;

  localparam int unsigned CH_TEMP_A  = 0;
  localparam int unsigned CH_TEMP_B  = 1;
  localparam int unsigned CH_RAIL12  = 2;
  localparam int unsigned CH_RAIL075 = 3;
  localparam int unsigned CH_CURRENT = 4;

  localparam sensor_id_t ID_TEMP_A  = 8'h04;
  localparam sensor_id_t ID_TEMP_B  = 8'h20;
  localparam sensor_id_t ID_RAIL12  = 8'h03;
  localparam sensor_id_t ID_RAIL075 = 8'h19;
  localparam sensor_id_t ID_CURRENT = 8'h07;
  localparam sensor_id_t ID_NONE    = 8'h00;

endpackage

// ----- hw/rtl/mchm_cfg_regs.sv -----
// Threshold register file written through the configuration port.
`timescale 1ns / 1ps

module mchm_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  mchm_pkg::cfg_idx_t       cfg_index,
  input  logic [mchm_pkg::MV_W-1:0] cfg_data,
  output mchm_pkg::thr_t           thr
);
  import mchm_pkg::*;

  thr_t thr_r;
  thr_t thr_nxt;

  assign cfg_ready = 1'b1;
  assign thr       = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEMP_ASSERT:     thr_nxt.temp_assert     = temp_t'(cfg_data[TEMP_W-1:0]);
        CFG_TEMP_CLEAR:      thr_nxt.temp_clear      = temp_t'(cfg_data[TEMP_W-1:0]);
        CFG_V12_LOW_ASSERT:  thr_nxt.v12_low_assert  = cfg_data;
        CFG_V12_HIGH_ASSERT: thr_nxt.v12_high_assert = cfg_data;
        CFG_V12_LOW_CLEAR:   thr_nxt.v12_low_clear   = cfg_data;
        CFG_V12_HIGH_CLEAR:  thr_nxt.v12_high_clear  = cfg_data;
        CFG_IOUT_ASSERT:     thr_nxt.iout_assert     = cfg_data;
        CFG_IOUT_CLEAR:      thr_nxt.iout_clear      = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.temp_assert     <= RST_TEMP_ASSERT;
      thr_r.temp_clear      <= RST_TEMP_CLEAR;
      thr_r.v12_low_assert  <= RST_V12_LOW_ASSERT;
      thr_r.v12_high_assert <= RST_V12_HIGH_ASSERT;
      thr_r.v12_low_clear   <= RST_V12_LOW_CLEAR;
      thr_r.v12_high_clear  <= RST_V12_HIGH_CLEAR;
      thr_r.iout_assert     <= RST_IOUT_ASSERT;
      thr_r.iout_clear      <= RST_IOUT_CLEAR;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

// ----- hw/rtl/multi_channel_hysteresis_monitor.sv -----
// Top level of the five-channel hysteresis monitor with event reporting.
`timescale 1ns / 1ps

// Each input beat carries one set of readings: two temperatures, the 12 V rail,
// two 0.75 V rail samples (averaged with a truncating halving) and the output
// current. Each input beat produces exactly one output beat holding the event
// kind, the high/low flag, the sensor id and the new exceeded mask.
// The input beat is captured in an input register; the channel compares and the
// mask update sit between that register and the output register. An output beat
// is presented by the output register after passing the input register. One
// beat per cycle is sustained while out_stall is low: both registers advance
// together and the mask state is updated in the same cycle as the compares
// that read it. A full output register holds while out_stall is high; the input
// register still fills once, and in_stall rises only when both hold a beat.
// Threshold registers are written through the cfg port, which is always ready;
// they should only be written while no beat is in flight.
// Synchronous reset empties both registers, clears the exceeded mask and loads
// the default thresholds.
module multi_channel_hysteresis_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [mchm_pkg::TEMP_W-1:0] in_temp_a_c,
  input  logic signed [mchm_pkg::TEMP_W-1:0] in_temp_b_c,
  input  logic [mchm_pkg::MV_W-1:0]      in_rail12_mv,
  input  logic [mchm_pkg::MV_W-1:0]      in_rail075_a_mv,
  input  logic [mchm_pkg::MV_W-1:0]      in_rail075_b_mv,
  input  logic [mchm_pkg::MV_W-1:0]      in_current_ma,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_event_kind,
  output logic                           out_trip_high,
  output logic [mchm_pkg::ID_W-1:0]      out_sensor_id,
  output logic [mchm_pkg::NCH-1:0]       out_exceeded_mask,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mchm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mchm_pkg::MV_W-1:0]      cfg_data
);
  import mchm_pkg::*;

  thr_t thr;

  mchm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // Input register stage.
  logic  s1_valid_r;
  temp_t s1_temp_a_r;
  temp_t s1_temp_b_r;
  mv_t   s1_rail12_r;
  mv_t   s1_rail075_a_r;
  mv_t   s1_rail075_b_r;
  mv_t   s1_current_r;

  // Output register stage and channel state.
  logic        out_valid_r;
  event_kind_t out_kind_r;
  logic        out_high_r;
  sensor_id_t  out_id_r;
  mask_t       out_mask_r;
  mask_t       exceeded_r;

  logic s2_adv;
  logic s1_adv;
  logic in_acc;

  assign s2_adv   = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_adv;
  assign in_stall = s1_valid_r && !s2_adv;
  assign in_acc   = in_valid && !in_stall;

  // Channel evaluation.
  logic [MV_W:0] r075_sum;
  mv_t           r075;
  mask_t         trip;
  mask_t         hold;
  logic          v12_hi;
  logic          v075_hi;
  mask_t         mask_nxt;
  sensor_id_t    id_nxt;
  logic          high_nxt;
  event_kind_t   kind_nxt;
  mask_t         fresh;

  assign r075_sum = {1'b0, s1_rail075_a_r} + {1'b0, s1_rail075_b_r};
  assign r075     = r075_sum[MV_W:1];
  assign v12_hi   = s1_rail12_r > thr.v12_high_assert;
  assign v075_hi  = r075 > V075_HIGH_ASSERT_MV;

  always_comb begin
    trip[CH_TEMP_A]  = s1_temp_a_r >= thr.temp_assert;
    trip[CH_TEMP_B]  = s1_temp_b_r >= thr.temp_assert;
    trip[CH_RAIL12]  = (s1_rail12_r < thr.v12_low_assert) || v12_hi;
    trip[CH_RAIL075] = (r075 < V075_LOW_ASSERT_MV) || v075_hi;
    trip[CH_CURRENT] = s1_current_r >= thr.iout_assert;

    hold[CH_TEMP_A]  = !(s1_temp_a_r <= thr.temp_clear);
    hold[CH_TEMP_B]  = !(s1_temp_b_r <= thr.temp_clear);
    hold[CH_RAIL12]  = !((s1_rail12_r >= thr.v12_low_clear) &&
                         (s1_rail12_r <= thr.v12_high_clear));
    hold[CH_RAIL075] = !((r075 >= V075_LOW_CLEAR_MV) && (r075 <= V075_HIGH_CLEAR_MV));
    hold[CH_CURRENT] = !(s1_current_r <= thr.iout_clear);

    mask_nxt = trip | (hold & exceeded_r);
    fresh    = trip & ~exceeded_r;

    // The last newly tripped channel in channel order is named.
    id_nxt   = ID_NONE;
    high_nxt = 1'b0;
    if (fresh[CH_TEMP_A]) begin
      id_nxt   = ID_TEMP_A;
      high_nxt = 1'b1;
    end
    if (fresh[CH_TEMP_B]) begin
      id_nxt   = ID_TEMP_B;
      high_nxt = 1'b1;
    end
    if (fresh[CH_RAIL12]) begin
      id_nxt   = ID_RAIL12;
      high_nxt = v12_hi;
    end
    if (fresh[CH_RAIL075]) begin
      id_nxt   = ID_RAIL075;
      high_nxt = v075_hi;
    end
    if (fresh[CH_CURRENT]) begin
      id_nxt   = ID_CURRENT;
      high_nxt = 1'b1;
    end

    priority if ((mask_nxt != '0) && (exceeded_r == '0)) begin
      kind_nxt = EV_ASSERT;
    end else if ((mask_nxt == '0) && (exceeded_r != '0)) begin
      kind_nxt = EV_CLEAR;
      id_nxt   = ID_NONE;
      high_nxt = 1'b0;
    end else begin
      kind_nxt = EV_NONE;
      id_nxt   = ID_NONE;
      high_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      exceeded_r  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        exceeded_r <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_temp_a_r    <= in_temp_a_c;
      s1_temp_b_r    <= in_temp_b_c;
      s1_rail12_r    <= in_rail12_mv;
      s1_rail075_a_r <= in_rail075_a_mv;
      s1_rail075_b_r <= in_rail075_b_mv;
      s1_current_r   <= in_current_ma;
    end
    if (s1_adv) begin
      out_kind_r <= kind_nxt;
      out_high_r <= high_nxt;
      out_id_r   <= id_nxt;
      out_mask_r <= mask_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_trip_high     = out_high_r;
  assign out_sensor_id     = out_id_r;
  assign out_exceeded_mask = out_mask_r;

  // A clear event always reports an empty mask.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_CLEAR)) |-> (out_mask_r == '0))
    else $error("clear event with nonzero mask");

  // An assert event names a channel that is set in the reported mask.
  a_assert_named: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_ASSERT)) |-> ((out_mask_r != '0) && (out_id_r != ID_NONE)))
    else $error("assert event without a named channel");

  // Only assert events carry an id or a high flag.
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != EV_ASSERT)) |-> ((out_id_r == ID_NONE) && !out_high_r))
    else $error("id or high flag set outside an assert event");

  // The mask state follows the mask of the beat just moved to the output.
  a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (exceeded_r == out_mask_r))
    else $error("exceeded state differs from reported mask");

  // Reset leaves the mask state empty.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (exceeded_r == '0))
    else $error("exceeded state not cleared by reset");

endmodule

// ----- tb/tb_multi_channel_hysteresis_monitor.sv -----
// Self-checking testbench for the five-channel hysteresis monitor with event reporting.
`timescale 1ns / 1ps

module tb_multi_channel_hysteresis_monitor;
  import mchm_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 5;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 171;
  localparam int DIRECTED_COUNT  = 25;
  localparam int OVERLAP_ROW     = 23;

  typedef struct packed {
    temp_t temp_a;
    temp_t temp_b;
    mv_t   rail12;
    mv_t   rail075_a;
    mv_t   rail075_b;
    mv_t   current;
  } reading_t;

  typedef struct packed {
    event_kind_t kind;
    logic        high;
    sensor_id_t  id;
    mask_t       mask;
  } trip_event_t;

  typedef struct packed {
    reading_t    rd;
    logic        typed;
    trip_event_t want;
  } probe_t;

  localparam trip_event_t NO_WANT = '{EV_NONE, 1'b0, ID_NONE, 5'h00};

  // Rows with typed expectations are checked against those values; the rest use the predictor.
  localparam probe_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{25, 25, 12000, 750, 750, 1000}, 1'b1, '{EV_NONE, 1'b0, ID_NONE, 5'h00}},
    '{'{85, 25, 12000, 750, 750, 1000}, 1'b1, '{EV_ASSERT, 1'b1, ID_TEMP_A, 5'h01}},
    '{'{82, 25, 12000, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{80, 25, 12000, 750, 750, 1000}, 1'b1, '{EV_CLEAR, 1'b0, ID_NONE, 5'h00}},
    '{'{127, -128, 0, 65535, 65535, 65535}, 1'b1, '{EV_ASSERT, 1'b1, ID_CURRENT, 5'h1D}},
    '{'{25, 25, 12000, 750, 750, 1000}, 1'b1, '{EV_CLEAR, 1'b0, ID_NONE, 5'h00}},
    '{'{25, 25, 0, 750, 750, 1000}, 1'b1, '{EV_ASSERT, 1'b0, ID_RAIL12, 5'h04}},
    '{'{25, 25, 10900, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 65535, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 13100, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 13000, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 13201, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 674, 675, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 675, 676, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 700, 701, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 826, 825, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 826, 827, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 0, 0, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 127, 12000, 750, 750, 1000}, 1'b1, '{EV_ASSERT, 1'b1, ID_TEMP_B, 5'h02}},
    '{'{25, 127, 12000, 750, 750, 40000}, 1'b0, NO_WANT},
    '{'{-1, 25, 12000, 750, 750, 1000}, 1'b0, NO_WANT},
    '{'{25, 25, 12000, 750, 750, 1000}, 1'b1, '{EV_ASSERT, 1'b1, ID_CURRENT, 5'h17}},
    '{'{-128, -128, 0, 0, 0, 0}, 1'b1, '{EV_NONE, 1'b0, ID_NONE, 5'h1F}}
  };

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  temp_t                 in_temp_a_c       = '0;
  temp_t                 in_temp_b_c       = '0;
  mv_t                   in_rail12_mv      = '0;
  mv_t                   in_rail075_a_mv   = '0;
  mv_t                   in_rail075_b_mv   = '0;
  mv_t                   in_current_ma     = '0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic [1:0]            out_event_kind;
  logic                  out_trip_high;
  logic [ID_W-1:0]       out_sensor_id;
  logic [NCH-1:0]        out_exceeded_mask;
  logic                  cfg_valid         = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index         = '0;
  logic [MV_W-1:0]       cfg_data          = '0;

  temp_t thr_temp_trip   = RST_TEMP_ASSERT;
  temp_t thr_temp_rec    = RST_TEMP_CLEAR;
  mv_t   thr_v12_lo_trip = RST_V12_LOW_ASSERT;
  mv_t   thr_v12_hi_trip = RST_V12_HIGH_ASSERT;
  mv_t   thr_v12_lo_rec  = RST_V12_LOW_CLEAR;
  mv_t   thr_v12_hi_rec  = RST_V12_HIGH_CLEAR;
  mv_t   thr_iout_trip   = RST_IOUT_ASSERT;
  mv_t   thr_iout_rec    = RST_IOUT_CLEAR;
  mask_t tripped_mask    = '0;

  trip_event_t expected_events [$];
  trip_event_t oldest_event;
  probe_t      rnd_probe;

  int tx_idle_pct    = 7;
  int rx_idle_pct    = 60;
  int fail_count     = 0;
  int idle_cycles    = 0;
  int readings_sent  = 0;
  int results_seen   = 0;
  int assert_events  = 0;
  int clear_events   = 0;
  int threshold_sets = 0;

  multi_channel_hysteresis_monitor u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_temp_a_c       (in_temp_a_c),
    .in_temp_b_c       (in_temp_b_c),
    .in_rail12_mv      (in_rail12_mv),
    .in_rail075_a_mv   (in_rail075_a_mv),
    .in_rail075_b_mv   (in_rail075_b_mv),
    .in_current_ma     (in_current_ma),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_trip_high     (out_trip_high),
    .out_sensor_id     (out_sensor_id),
    .out_exceeded_mask (out_exceeded_mask),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic trip_event_t predict_event(input reading_t r);
    temp_t       ta;
    temp_t       tb;
    logic [MV_W:0] sum075;
    mv_t         avg075;
    mask_t       trip;
    mask_t       hold;
    mask_t       hi;
    mask_t       nm;
    sensor_id_t  ids [NCH];
    sensor_id_t  last_id;
    logic        last_hi;
    trip_event_t ev;
    ids = '{ID_TEMP_A, ID_TEMP_B, ID_RAIL12, ID_RAIL075, ID_CURRENT};
    ta = r.temp_a;
    tb = r.temp_b;
    sum075 = {1'b0, r.rail075_a} + {1'b0, r.rail075_b};
    avg075 = sum075[MV_W:1];
    trip[CH_TEMP_A] = ta >= thr_temp_trip;
    hold[CH_TEMP_A] = !(ta <= thr_temp_rec);
    hi[CH_TEMP_A]   = 1'b1;
    trip[CH_TEMP_B] = tb >= thr_temp_trip;
    hold[CH_TEMP_B] = !(tb <= thr_temp_rec);
    hi[CH_TEMP_B]   = 1'b1;
    trip[CH_RAIL12] = (r.rail12 < thr_v12_lo_trip) || (r.rail12 > thr_v12_hi_trip);
    hold[CH_RAIL12] = !((r.rail12 >= thr_v12_lo_rec) && (r.rail12 <= thr_v12_hi_rec));
    hi[CH_RAIL12]   = r.rail12 > thr_v12_hi_trip;
    trip[CH_RAIL075] = (avg075 < V075_LOW_ASSERT_MV) || (avg075 > V075_HIGH_ASSERT_MV);
    hold[CH_RAIL075] = !((avg075 >= V075_LOW_CLEAR_MV) && (avg075 <= V075_HIGH_CLEAR_MV));
    hi[CH_RAIL075]   = avg075 > V075_HIGH_ASSERT_MV;
    trip[CH_CURRENT] = r.current >= thr_iout_trip;
    hold[CH_CURRENT] = !(r.current <= thr_iout_rec);
    hi[CH_CURRENT]   = 1'b1;
    nm = '0;
    last_id = ID_NONE;
    last_hi = 1'b0;
    // Only a channel that was not already exceeded can be named by the event.
    for (int ch = 0; ch < NCH; ch++) begin
      if (trip[ch]) begin
        nm[ch] = 1'b1;
        if (!tripped_mask[ch]) begin
          last_id = ids[ch];
          last_hi = hi[ch];
        end
      end else if (hold[ch] && tripped_mask[ch]) begin
        nm[ch] = 1'b1;
      end
    end
    if (nm != '0 && tripped_mask == '0) begin
      ev = '{EV_ASSERT, last_hi, last_id, nm};
    end else if (nm == '0 && tripped_mask != '0) begin
      ev = '{EV_CLEAR, 1'b0, ID_NONE, nm};
    end else begin
      ev = '{EV_NONE, 1'b0, ID_NONE, nm};
    end
    return ev;
  endfunction

  function automatic temp_t pick_temp();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 55) begin
      v = int'(thr_temp_rec) - int'($urandom_range(12));
    end else if (sel < 85) begin
      v = ($urandom_range(1) ? int'(thr_temp_trip) : int'(thr_temp_rec))
          + int'($urandom_range(6)) - 3;
    end else if (sel < 92) begin
      v = $urandom_range(1) ? 127 : -128;
    end else begin
      v = int'($urandom_range(255)) - 128;
    end
    return temp_t'(clamp(v, -128, 127));
  endfunction

  function automatic mv_t pick_mv(input mv_t q_lo, q_hi, t0, t1, t2, t3, input int spread);
    int  sel;
    int  v;
    mv_t near_pt;
    sel = $urandom_range(99);
    case ($urandom_range(3))
      0: near_pt = t0;
      1: near_pt = t1;
      2: near_pt = t2;
      default: near_pt = t3;
    endcase
    if (sel < 55) begin
      v = (q_lo <= q_hi) ? int'($urandom_range(q_hi, q_lo)) : int'($urandom_range(16'hFFFF));
    end else if (sel < 85) begin
      v = int'(near_pt) + int'($urandom_range(2 * spread)) - spread;
    end else if (sel < 92) begin
      v = $urandom_range(1) ? 65535 : 0;
    end else begin
      v = $urandom_range(16'hFFFF);
    end
    return mv_t'(clamp(v, 0, 65535));
  endfunction

  function automatic reading_t gen_reading();
    reading_t r;
    mv_t      avg;
    int       d;
    r.temp_a = pick_temp();
    r.temp_b = pick_temp();
    r.rail12 = pick_mv(thr_v12_lo_rec, thr_v12_hi_rec, thr_v12_lo_trip, thr_v12_hi_trip,
                       thr_v12_lo_rec, thr_v12_hi_rec, 40);
    avg = pick_mv(V075_LOW_CLEAR_MV, V075_HIGH_CLEAR_MV, V075_LOW_ASSERT_MV,
                  V075_HIGH_ASSERT_MV, V075_LOW_CLEAR_MV, V075_HIGH_CLEAR_MV, 3);
    if ($urandom_range(9) == 0) begin
      r.rail075_a = mv_t'($urandom);
      r.rail075_b = mv_t'($urandom);
    end else begin
      // The odd bit of the sum is dropped by the halving, so the average stays at avg.
      d = $urandom_range(3);
      r.rail075_a = mv_t'(clamp(int'(avg) + d, 0, 65535));
      r.rail075_b = mv_t'(clamp(int'(avg) - d + int'($urandom_range(1)), 0, 65535));
    end
    r.current = pick_mv(16'd0, thr_iout_rec, thr_iout_trip, thr_iout_rec,
                        thr_iout_trip, thr_iout_rec, 40);
    return r;
  endfunction

  task automatic send_probe(input probe_t p);
    trip_event_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_temp_a_c     <= p.rd.temp_a;
    in_temp_b_c     <= p.rd.temp_b;
    in_rail12_mv    <= p.rd.rail12;
    in_rail075_a_mv <= p.rd.rail075_a;
    in_rail075_b_mv <= p.rd.rail075_b;
    in_current_ma   <= p.rd.current;
    do @(posedge clk); while (in_stall);
    predicted = predict_event(p.rd);
    tripped_mask = predicted.mask;
    expected_events.push_back(p.typed ? p.want : predicted);
    readings_sent++;
    if (predicted.kind == EV_ASSERT) assert_events++;
    if (predicted.kind == EV_CLEAR) clear_events++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input mv_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEMP_ASSERT:     thr_temp_trip   = temp_t'(data[TEMP_W-1:0]);
      CFG_TEMP_CLEAR:      thr_temp_rec    = temp_t'(data[TEMP_W-1:0]);
      CFG_V12_LOW_ASSERT:  thr_v12_lo_trip = data;
      CFG_V12_HIGH_ASSERT: thr_v12_hi_trip = data;
      CFG_V12_LOW_CLEAR:   thr_v12_lo_rec  = data;
      CFG_V12_HIGH_CLEAR:  thr_v12_hi_rec  = data;
      CFG_IOUT_ASSERT:     thr_iout_trip   = data;
      default:             thr_iout_rec    = data;
    endcase
  endtask

  task automatic load_thresholds(input temp_t t_trip, t_rec,
                                 input mv_t v_lo_trip, v_hi_trip, v_lo_rec, v_hi_rec,
                                 input mv_t i_trip, i_rec);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    // The upper byte of a temperature write is don't-care, so it carries noise.
    write_reg(CFG_TEMP_ASSERT, {8'($urandom_range(255)), t_trip});
    write_reg(CFG_TEMP_CLEAR, {8'($urandom_range(255)), t_rec});
    write_reg(CFG_V12_LOW_ASSERT, v_lo_trip);
    write_reg(CFG_V12_HIGH_ASSERT, v_hi_trip);
    write_reg(CFG_V12_LOW_CLEAR, v_lo_rec);
    write_reg(CFG_V12_HIGH_CLEAR, v_hi_rec);
    write_reg(CFG_IOUT_ASSERT, i_trip);
    write_reg(CFG_IOUT_CLEAR, i_rec);
    cfg_valid <= 1'b0;
    threshold_sets++;
  endtask

  task automatic load_random_thresholds(input bit ordered);
    int t_rec;
    int center;
    int lc;
    int hc;
    int ic;
    if (ordered) begin
      t_rec  = int'($urandom_range(110)) - 20;
      center = $urandom_range(60000, 2000);
      lc     = center - int'($urandom_range(1500, 100));
      hc     = center + int'($urandom_range(1500, 100));
      ic     = $urandom_range(60000, 1000);
      load_thresholds(temp_t'(t_rec + int'($urandom_range(15))), temp_t'(t_rec),
                      mv_t'(lc - int'($urandom_range(500))), mv_t'(hc + int'($urandom_range(500))),
                      mv_t'(lc), mv_t'(hc), mv_t'(ic + int'($urandom_range(3000))), mv_t'(ic));
    end else begin
      load_thresholds(temp_t'($urandom), temp_t'($urandom), mv_t'($urandom), mv_t'($urandom),
                      mv_t'($urandom), mv_t'($urandom), mv_t'($urandom), mv_t'($urandom));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_events.size() == 0) begin
        $error("result beat with no expectation pending, mask %0h", out_exceeded_mask);
        fail_count++;
      end else begin
        oldest_event = expected_events.pop_front();
        if (out_event_kind !== oldest_event.kind) begin
          $error("event_kind: expected %0d, got %0d", oldest_event.kind, out_event_kind);
          fail_count++;
        end
        if (out_trip_high !== oldest_event.high) begin
          $error("trip_high: expected %0d, got %0d", oldest_event.high, out_trip_high);
          fail_count++;
        end
        if (out_sensor_id !== oldest_event.id) begin
          $error("sensor_id: expected %0h, got %0h", oldest_event.id, out_sensor_id);
          fail_count++;
        end
        if (out_exceeded_mask !== oldest_event.mask) begin
          $error("exceeded_mask: expected %0h, got %0h", oldest_event.mask, out_exceeded_mask);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
      $display("multi_channel_hysteresis_monitor verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (i == OVERLAP_ROW) begin
        load_thresholds(temp_t'(-128), temp_t'(127), 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                        16'h0000, 16'hFFFF);
      end
      send_probe(DIRECTED_ROWS[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          load_thresholds(RST_TEMP_ASSERT, RST_TEMP_CLEAR, RST_V12_LOW_ASSERT,
                          RST_V12_HIGH_ASSERT, RST_V12_LOW_CLEAR, RST_V12_HIGH_CLEAR,
                          RST_IOUT_ASSERT, RST_IOUT_CLEAR);
        end
        1: begin
          load_thresholds(temp_t'(127), temp_t'(-128), 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                          16'hFFFF, 16'h0000);
        end
        2: begin
          tx_idle_pct = 60;
          rx_idle_pct = 7;
          load_random_thresholds(1'b1);
        end
        3: begin
          load_thresholds(temp_t'(-128), temp_t'(127), 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                          16'h0000, 16'hFFFF);
        end
        4: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          load_random_thresholds(1'b1);
        end
        default: begin
          load_random_thresholds(1'b0);
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        rnd_probe.rd    = gen_reading();
        rnd_probe.typed = 1'b0;
        rnd_probe.want  = NO_WANT;
        send_probe(rnd_probe);
      end
    end

    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_events.size());
      fail_count++;
    end

    $display("Checked %0d result beats for %0d readings under %0d threshold settings.",
             results_seen, readings_sent, threshold_sets);
    $display("The run saw %0d assert events and %0d clear events; %0d mismatches.",
             assert_events, clear_events, fail_count);
    if (fail_count == 0) begin
      $display("multi_channel_hysteresis_monitor verification clean");
    end else begin
      $display("multi_channel_hysteresis_monitor verification failed");
    end
    $finish;
  end

endmodule
